### rtl/core/modrb_pkg.sv
// Shared types, widths and codes of the modal resonator bank.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package modrb_pkg;

  localparam int MODES      = 64;
  localparam int SAMPLE_W   = 24;
  localparam int HIST_W     = 40;
  localparam int FRAC       = SAMPLE_W - 2;
  localparam int DECAY_W    = SAMPLE_W - 1;
  localparam int IDX_W      = $clog2(MODES);
  localparam int MODE_IDX_W = 6;
  localparam int ACT_W      = 7;
  localparam int SCALE_W    = 17;
  localparam int SCALE_FRAC = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;

  // mode unit pipeline: LAT is the number of register stages between the head read and the result
  localparam int LAT    = 2;
  localparam int WB_POS = MODES - 1 - LAT;
  localparam int CNT_W  = $clog2(MODES + LAT);

  // mode unit widths
  localparam int HI_W   = HIST_W - FRAC;
  localparam int PH_W   = SAMPLE_W + HI_W;
  localparam int PL_W   = SAMPLE_W + FRAC + 1;
  localparam int PG_W   = 2 * SAMPLE_W;
  localparam int HSUM_W = PH_W + 1;
  localparam int LSUM_W = PG_W + 2;
  localparam int HC_W   = HIST_W + 1;
  localparam int LS_W   = LSUM_W - FRAC;
  localparam int YS_W   = HC_W + 1;

  localparam logic signed [LSUM_W-1:0] LO_HALF = LSUM_W'(1) <<< (FRAC - 1);
  localparam logic signed [HSUM_W-1:0] HC_MAX  = (HSUM_W'(1) <<< (HIST_W - 1)) + HSUM_W'(7);
  localparam logic signed [HSUM_W-1:0] HC_MIN  = -(HSUM_W'(1) <<< (HIST_W - 1)) - HSUM_W'(8);
  localparam logic signed [YS_W-1:0]   Y_MAX   = (YS_W'(1) <<< (HIST_W - 1)) - YS_W'(1);
  localparam logic signed [YS_W-1:0]   Y_MIN   = -(YS_W'(1) <<< (HIST_W - 1));

  // sum, scaling and clipping widths
  localparam int ACC_W  = HIST_W + IDX_W + 1;
  localparam int LIM_W  = FRAC + 19;
  localparam int PROD_W = LIM_W + SCALE_W + 1;
  localparam int RND_W  = PROD_W - SCALE_FRAC;

  localparam logic signed [ACC_W-1:0]  SUM_LIM   = ACC_W'(1) <<< (FRAC + 17);
  localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(1) <<< (SCALE_FRAC - 1);
  localparam logic signed [RND_W-1:0]  OUT_ONE   = RND_W'(1) <<< FRAC;
  localparam logic [SCALE_W-1:0]       SCALE_RST = SCALE_W'(1) << SCALE_FRAC;

  // input tdata layout, lowest bit first
  localparam int FRC_LSB    = 0;
  localparam int MIDX_LSB   = FRC_LSB + SAMPLE_W;
  localparam int COS_LSB    = MIDX_LSB + MODE_IDX_W;
  localparam int DECAY_LSB  = COS_LSB + SAMPLE_W;
  localparam int GAIN_LSB   = DECAY_LSB + DECAY_W;
  localparam int IN_BITS    = GAIN_LSB + SAMPLE_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_MODES = 1'b0,
    CFG_OUTPUT_SCALE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_LIMIT,
    ST_SCALE,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cos_c;
    logic [DECAY_W-1:0]         decay_c;
    logic signed [SAMPLE_W-1:0] gain_c;
    logic signed [HIST_W-1:0]   h1;
    logic signed [HIST_W-1:0]   h2;
  } mode_elem_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
    logic wb;
  } ring_ctl_t;

  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(MODES)) begin
      s = s - (IDX_W + 1)'(MODES);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/modrb_cell.sv
// One slot of the mode ring: coefficients and two history words of one mode.
// Depends on modrb_pkg.
`default_nettype none
module modrb_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire modrb_pkg::cell_ctl_t   ctl,
  input  wire modrb_pkg::mode_elem_t  shift_in,
  input  wire modrb_pkg::mode_elem_t  load_in,
  output modrb_pkg::mode_elem_t       elem_q
);
  import modrb_pkg::*;

  logic signed [SAMPLE_W-1:0] cos_r;
  logic [DECAY_W-1:0]         decay_r;
  logic signed [SAMPLE_W-1:0] gain_r;
  logic signed [HIST_W-1:0]   h1_r;
  logic signed [HIST_W-1:0]   h2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= '0;
      h2_r <= '0;
    end else if (ctl.shift) begin
      h1_r <= shift_in.h1;
      h2_r <= shift_in.h2;
    end else if (ctl.clear) begin
      h1_r <= '0;
      h2_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      cos_r   <= shift_in.cos_c;
      decay_r <= shift_in.decay_c;
      gain_r  <= shift_in.gain_c;
    end else if (ctl.load) begin
      cos_r   <= load_in.cos_c;
      decay_r <= load_in.decay_c;
      gain_r  <= load_in.gain_c;
    end
  end

  always_comb begin
    elem_q.cos_c   = cos_r;
    elem_q.decay_c = decay_r;
    elem_q.gain_c  = gain_r;
    elem_q.h1      = h1_r;
    elem_q.h2      = h2_r;
  end

endmodule
`default_nettype wire

### rtl/core/modrb_mode_unit.sv
// Shared two-pole update: y = c1*y1 - c2*y2 + g*x, rounded and saturated.
// Two register stages; depends on modrb_pkg.
`default_nettype none
module modrb_mode_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  rd_vld,
  input  wire modrb_pkg::mode_elem_t                 elem,
  input  wire logic signed [modrb_pkg::SAMPLE_W-1:0] excite,
  output logic                                       y_vld,
  output logic signed [modrb_pkg::HIST_W-1:0]        y
);
  import modrb_pkg::*;

  logic signed [HI_W-1:0]     h1_hi, h2_hi;
  logic [FRAC-1:0]            h1_lo, h2_lo;
  logic signed [SAMPLE_W-1:0] c2_s;
  logic signed [FRAC:0]       l1_s, l2_s;

  logic signed [PH_W-1:0] p_c1h_nxt, p_c2h_nxt, p_c1h_r, p_c2h_r;
  logic signed [PL_W-1:0] p_c1l_nxt, p_c2l_nxt, p_c1l_r, p_c2l_r;
  logic signed [PG_W-1:0] p_gf_nxt, p_gf_r;

  logic signed [HSUM_W-1:0] hsum;
  logic signed [LSUM_W-1:0] lsum;
  logic signed [HC_W-1:0]   hic_nxt, hic_r;
  logic signed [LS_W-1:0]   losh_nxt, losh_r;
  logic signed [YS_W-1:0]   ysum;

  logic v1_r, v2_r;

  always_comb begin
    h1_hi = elem.h1[HIST_W-1:FRAC];
    h2_hi = elem.h2[HIST_W-1:FRAC];
    h1_lo = elem.h1[FRAC-1:0];
    h2_lo = elem.h2[FRAC-1:0];
    c2_s  = $signed({1'b0, elem.decay_c});
    l1_s  = $signed({1'b0, h1_lo});
    l2_s  = $signed({1'b0, h2_lo});
    p_c1h_nxt = PH_W'(elem.cos_c) * PH_W'(h1_hi);
    p_c2h_nxt = PH_W'(c2_s) * PH_W'(h2_hi);
    p_c1l_nxt = PL_W'(elem.cos_c) * PL_W'(l1_s);
    p_c2l_nxt = PL_W'(c2_s) * PL_W'(l2_s);
    p_gf_nxt  = PG_W'(elem.gain_c) * PG_W'(excite);
  end

  always_comb begin
    hsum = HSUM_W'(p_c1h_r) - HSUM_W'(p_c2h_r);
    lsum = LSUM_W'(p_c1l_r) - LSUM_W'(p_c2l_r) + LSUM_W'(p_gf_r) + LO_HALF;
    priority if (hsum > HC_MAX) begin
      hic_nxt = HC_W'(HC_MAX);
    end else if (hsum < HC_MIN) begin
      hic_nxt = HC_W'(HC_MIN);
    end else begin
      hic_nxt = HC_W'(hsum);
    end
    losh_nxt = LS_W'(lsum >>> FRAC);
  end

  always_comb begin
    ysum = YS_W'(hic_r) + YS_W'(losh_r);
    priority if (ysum > Y_MAX) begin
      y = HIST_W'(Y_MAX);
    end else if (ysum < Y_MIN) begin
      y = HIST_W'(Y_MIN);
    end else begin
      y = HIST_W'(ysum);
    end
  end

  always_ff @(posedge clk) begin
    p_c1h_r <= p_c1h_nxt;
    p_c2h_r <= p_c2h_nxt;
    p_c1l_r <= p_c1l_nxt;
    p_c2l_r <= p_c2l_nxt;
    p_gf_r  <= p_gf_nxt;
    hic_r   <= hic_nxt;
    losh_r  <= losh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= rd_vld;
      v2_r <= v1_r;
    end
  end

  assign y_vld = v2_r;

endmodule
`default_nettype wire

### rtl/core/modrb_ring.sv
// Ring of mode slots rotating toward slot 0; updated history re-enters at a fixed slot.
// Depends on modrb_pkg and modrb_cell.
`default_nettype none
module modrb_ring (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire modrb_pkg::ring_ctl_t                ctl,
  input  wire logic [modrb_pkg::IDX_W-1:0]         load_pos,
  input  wire modrb_pkg::mode_elem_t               load_elem,
  input  wire logic signed [modrb_pkg::HIST_W-1:0] wb_y,
  output modrb_pkg::mode_elem_t                    head
);
  import modrb_pkg::*;

  mode_elem_t slot_q [MODES];

  for (genvar i = 0; i < MODES; i++) begin : g_slot
    localparam int NXT = (i + 1) % MODES;
    mode_elem_t nxt_in;
    cell_ctl_t  cctl;

    if (i == WB_POS) begin : g_wb
      always_comb begin
        nxt_in = slot_q[NXT];
        if (ctl.wb) begin
          nxt_in.h1 = wb_y;
          nxt_in.h2 = slot_q[NXT].h1;
        end
      end
    end else begin : g_pass
      always_comb begin
        nxt_in = slot_q[NXT];
      end
    end

    always_comb begin
      cctl.shift = ctl.shift;
      cctl.clear = ctl.clear;
      cctl.load  = ctl.load && (load_pos == IDX_W'(i));
    end

    modrb_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cctl),
      .shift_in (nxt_in),
      .load_in  (load_elem),
      .elem_q   (slot_q[i])
    );
  end

  assign head = slot_q[0];

endmodule
`default_nettype wire

### rtl/core/modal_resonator_bank_unit.sv
// Top level of the modal resonator bank: stream ports, config registers, sequencer,
// mode sum, output scaling and clipping. Depends on modrb_pkg, modrb_ring, modrb_mode_unit.
//
// Input stream: in_tuser carries the command, in_tdata the force sample, mode index and
// the three coefficients of a load. A load or clear transaction gives no output. A sample
// transaction gives one output transaction: the sum of modes 0..active_modes-1, scaled by
// output_scale, clipped to +-1.0 with the clip flag in out_tuser.
// Sequence: a sample rotates the whole ring, one mode per cycle through the shared two-pole
// unit, while the mode unit pipeline drains, then passes through the limit, scale and round
// steps; no new transaction is accepted until its result is in the output register.
// Load and clear are accepted back to back.
// The output register holds a result while out_tready is low; a following sample runs
// its rotation and then waits in its last step until the output register frees.
// Configuration writes are taken in any cycle and should only be issued while idle.
// Reset zeroes all filter history, sets active_modes to 0 and output_scale to 1.0;
// coefficients are undefined until loaded.
`default_nettype none
module modal_resonator_bank_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // force_req[23:0], mode_index[29:24], cos_coef[53:30], decay_coef[76:54],
  // mode_gain[100:77], zero fill[103:101]
  input  wire logic [modrb_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[1:0]
  input  wire logic [modrb_pkg::CMD_W-1:0]        in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // sample_out[23:0]
  output logic [modrb_pkg::OUT_DATA_W-1:0]        out_tdata,
  // clipped[0]
  output logic                                    out_tuser,
  input  wire logic                               cfg_wr_en,
  input  wire logic [modrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [modrb_pkg::SCALE_W-1:0]      cfg_wdata
);
  import modrb_pkg::*;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]   active_modes_r;
  logic [SCALE_W-1:0] output_scale_r;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           rot_r, rot_nxt;
  logic signed [SAMPLE_W-1:0] excite_r, excite_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [LIM_W-1:0]    lim_r, lim_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_data_r, out_data_nxt;
  logic                       out_clip_r, out_clip_nxt;

  cmd_t                       cmd;
  logic                       in_acc;
  logic                       out_free;
  logic [IDX_W-1:0]           mode_now;
  logic                       mode_active;
  logic [IDX_W-1:0]           rot_neg;
  logic [IDX_W-1:0]           load_pos;
  logic                       load_ok;
  mode_elem_t                 load_elem;
  ring_ctl_t                  ring_ctl;
  mode_elem_t                 head;
  logic                       rd_vld;
  logic                       y_vld;
  logic signed [HIST_W-1:0]   y;
  logic signed [SCALE_W:0]    scale_s;
  logic signed [PROD_W-1:0]   rsum;
  logic signed [RND_W-1:0]    rnd;

  modrb_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .load_pos  (load_pos),
    .load_elem (load_elem),
    .wb_y      (y),
    .head      (head)
  );

  modrb_mode_unit u_mode (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_vld (rd_vld),
    .elem   (head),
    .excite (excite_r),
    .y_vld  (y_vld),
    .y      (y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_modes_r <= '0;
      output_scale_r <= SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_MODES: active_modes_r <= cfg_wdata[ACT_W-1:0];
        CFG_OUTPUT_SCALE: output_scale_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    cmd      = cmd_t'(in_tuser);
    in_acc   = in_tvalid && (state_r == ST_IDLE);
    out_free = !out_valid_r || out_tready;

    mode_now    = idx_add(rot_r, cnt_r[IDX_W-1:0]);
    mode_active = ACT_W'(mode_now) < active_modes_r;

    rot_neg  = (rot_r == '0) ? '0 : IDX_W'((IDX_W + 1)'(MODES) - {1'b0, rot_r});
    load_pos = idx_add(in_tdata[MIDX_LSB +: IDX_W], rot_neg);
    load_ok  = (MODE_IDX_W + 1)'(in_tdata[MIDX_LSB +: MODE_IDX_W])
               < (MODE_IDX_W + 1)'(MODES);

    load_elem.cos_c   = in_tdata[COS_LSB +: SAMPLE_W];
    load_elem.decay_c = in_tdata[DECAY_LSB +: DECAY_W];
    load_elem.gain_c  = in_tdata[GAIN_LSB +: SAMPLE_W];
    load_elem.h1      = '0;
    load_elem.h2      = '0;

    scale_s = $signed({1'b0, output_scale_r});
    rsum    = prod_r + RND_HALF;
    rnd     = RND_W'(rsum >>> SCALE_FRAC);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rot_nxt       = rot_r;
    excite_nxt    = excite_r;
    acc_nxt       = acc_r;
    lim_nxt       = lim_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_clip_nxt  = out_clip_r;
    ring_ctl      = '0;
    rd_vld        = 1'b0;

    if (y_vld) begin
      acc_nxt = acc_r + ACC_W'(y);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_SAMPLE: begin
              excite_nxt = in_tdata[FRC_LSB +: SAMPLE_W];
              acc_nxt    = '0;
              cnt_nxt    = '0;
              state_nxt  = ST_ROTATE;
            end
            CMD_LOAD:  ring_ctl.load  = load_ok;
            CMD_CLEAR: ring_ctl.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ROTATE: begin
        ring_ctl.shift = 1'b1;
        ring_ctl.wb    = y_vld;
        rd_vld         = (cnt_r < CNT_W'(MODES)) && mode_active;
        cnt_nxt        = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MODES + LAT - 1)) begin
          rot_nxt   = idx_add(rot_r, IDX_W'(LAT));
          state_nxt = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        priority if (acc_r > SUM_LIM) begin
          lim_nxt = LIM_W'(SUM_LIM);
        end else if (acc_r < -SUM_LIM) begin
          lim_nxt = LIM_W'(-SUM_LIM);
        end else begin
          lim_nxt = LIM_W'(acc_r);
        end
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        prod_nxt  = PROD_W'(lim_r) * PROD_W'(scale_s);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          priority if (rnd > OUT_ONE) begin
            out_data_nxt = SAMPLE_W'(OUT_ONE);
            out_clip_nxt = 1'b1;
          end else if (rnd < -OUT_ONE) begin
            out_data_nxt = SAMPLE_W'(-OUT_ONE);
            out_clip_nxt = 1'b1;
          end else begin
            out_data_nxt = SAMPLE_W'(rnd);
            out_clip_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    excite_r   <= excite_nxt;
    acc_r      <= acc_nxt;
    lim_r      <= lim_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tuser  = out_clip_r;

endmodule
`default_nettype wire
